@@ hdl/dpp_pkg.sv @@
// Shared constants and types for the derivation path parser.
`default_nettype none
package dpp_pkg;

    // Largest component count the hardware allows, whatever the register says
    localparam logic [4:0] MAX_COMPONENTS = 5'd16;
    localparam logic [4:0] MAX_COMP_RESET = 5'd16;

    // Largest component value without the hardened bit
    localparam logic [34:0] INDEX_LIMIT = 35'h07FFF_FFFF;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LO_M  = 8'h6D;
    localparam logic [7:0] CH_UP_M  = 8'h4D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_LO_H  = 8'h68;
    localparam logic [7:0] CH_UP_H  = 8'h48;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Summary status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SYNTAX  = 2'd1;
    localparam logic [1:0] ST_TOOMANY = 2'd2;

    // Result kinds
    localparam logic KIND_COMPONENT = 1'b0;
    localparam logic KIND_SUMMARY   = 1'b1;

    // Output queue depth
    localparam int unsigned QUEUE_DEPTH = 3;

    // One result beat
    typedef struct packed {
        logic        kind;
        logic [31:0] index_value;
        logic [1:0]  status;
        logic [4:0]  component_count;
        logic        last_result;
    } result_t;

endpackage
`default_nettype wire

@@ hdl/derivation_path_parser.sv @@
// Top level: streaming key-path parser, one character beat in, component and summary beats out.
//
// Path characters arrive one per beat on the s_ channel (s_tdata = char_byte).
// A zero byte ends the path. Each component that closes validly produces a
// component beat (m_tuser = 0) carrying its index, bit 31 set when hardened.
// The terminator produces a summary beat (m_tuser = 1) with status and count.
// m_tlast marks the last beat caused by one input character.
// The parse state updates at the accepting edge; results are registered into a
// three-entry output queue whose head register drives the m_ channel.
// Throughput is one character per cycle while s_tready is high. A character
// that closes a component and ends the path yields two beats; s_tready drops
// while the queue holds two or more beats.
// When the receiver stalls, the queue fills and s_tready goes low; nothing is
// lost. Reset clears the parse state, empties the queue and sets the
// component limit register to 16. cfg_we writes the limit (used as the
// smaller of it and 16); the user is to use it only while the block is idle,
// which the block itself does not enforce.
`default_nettype none
module derivation_path_parser
    import dpp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,     // max_components
    // character input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] char_byte
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,       // [31:0] index_value, [33:32] status,
                                            // [38:34] component_count, [39] zero
    output logic             m_tuser,       // result_kind
    output logic             m_tlast        // last_result
);

    typedef enum logic [2:0] {
        PH_START,
        PH_AFTER_M,
        PH_EXPECT,
        PH_DIGITS,
        PH_MARKED,
        PH_ERROR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [30:0] accum_reg, accum_next;
    logic        ovf_reg, ovf_next;
    logic        hard_reg, hard_next;
    logic [4:0]  seen_reg, seen_next;
    logic [1:0]  error_code_reg, error_code_next;
    logic [4:0]  max_comp_reg;

    result_t     queue_reg [QUEUE_DEPTH];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fifo_count_reg, fifo_count_next;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        ptr_inc = (p == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    // Handshakes
    logic accept_beat, pop_beat;
    assign s_tready    = (fifo_count_reg <= 2'd1);
    assign accept_beat = s_tvalid && s_tready;
    assign pop_beat    = m_tvalid && m_tready;

    // Character classes and digit arithmetic
    logic        is_digit, is_marker, too_many;
    logic [3:0]  digit;
    logic [4:0]  limit;
    logic [34:0] accum_x10;
    assign is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign is_marker = (s_tdata == CH_APOS) || (s_tdata == CH_LO_H) || (s_tdata == CH_UP_H);
    assign digit     = s_tdata[3:0];
    assign limit     = (max_comp_reg > MAX_COMPONENTS) ? MAX_COMPONENTS : max_comp_reg;
    assign too_many  = (seen_reg >= limit);
    assign accum_x10 = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                       + {31'd0, digit};

    // Parse step
    result_t    res0, res1;
    logic [1:0] n_res;
    logic [4:0] seen_inc;
    logic       do_begin, do_summary;
    logic [1:0] summary_status;
    assign seen_inc = seen_reg + 5'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        accum_next      = accum_reg;
        ovf_next        = ovf_reg;
        hard_next       = hard_reg;
        seen_next       = seen_reg;
        error_code_next = error_code_reg;
        res0            = '0;
        res1            = '0;
        n_res           = 2'd0;
        do_begin        = 1'b0;
        do_summary      = 1'b0;
        summary_status  = ST_OK;

        case (phase_reg)
            PH_START:
            begin
                if (s_tdata == CH_NUL)
                    do_summary = 1'b1;
                else if (s_tdata == CH_LO_M || s_tdata == CH_UP_M)
                    phase_next = PH_AFTER_M;
                else
                    do_begin = 1'b1;
            end
            PH_AFTER_M:
            begin
                if (s_tdata == CH_NUL)
                    do_summary = 1'b1;
                else if (s_tdata == CH_SLASH)
                    phase_next = PH_EXPECT;
                else
                    do_begin = 1'b1;
            end
            PH_EXPECT:
            begin
                if (s_tdata == CH_NUL)
                begin
                    do_summary     = 1'b1;
                    summary_status = ST_SYNTAX;
                end
                else
                    do_begin = 1'b1;
            end
            PH_DIGITS:
            begin
                if (is_digit)
                begin
                    if (ovf_reg || accum_x10 > INDEX_LIMIT)
                        ovf_next = 1'b1;
                    else
                        accum_next = accum_x10[30:0];
                end
                else if (ovf_reg)
                begin
                    if (s_tdata == CH_NUL)
                    begin
                        do_summary     = 1'b1;
                        summary_status = ST_SYNTAX;
                    end
                    else
                    begin
                        phase_next      = PH_ERROR;
                        error_code_next = ST_SYNTAX;
                    end
                end
                else if (is_marker)
                begin
                    hard_next  = 1'b1;
                    phase_next = PH_MARKED;
                end
                else if (s_tdata == CH_SLASH || s_tdata == CH_NUL)
                begin
                    res0.kind        = KIND_COMPONENT;
                    res0.index_value = {hard_reg, accum_reg};
                    seen_next        = seen_inc;
                    if (s_tdata == CH_SLASH)
                    begin
                        res0.last_result = 1'b1;
                        n_res            = 2'd1;
                        phase_next       = PH_EXPECT;
                    end
                    else
                        do_summary = 1'b1;
                end
                else
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = ST_SYNTAX;
                end
            end
            PH_MARKED:
            begin
                if (s_tdata == CH_SLASH || s_tdata == CH_NUL)
                begin
                    res0.kind        = KIND_COMPONENT;
                    res0.index_value = {hard_reg, accum_reg};
                    seen_next        = seen_inc;
                    if (s_tdata == CH_SLASH)
                    begin
                        res0.last_result = 1'b1;
                        n_res            = 2'd1;
                        phase_next       = PH_EXPECT;
                    end
                    else
                        do_summary = 1'b1;
                end
                else
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = ST_SYNTAX;
                end
            end
            default:
            begin
                phase_next = PH_ERROR;
                if (phase_reg != PH_ERROR)
                    error_code_next = ST_SYNTAX;
                if (s_tdata == CH_NUL)
                begin
                    do_summary     = 1'b1;
                    summary_status = (phase_reg != PH_ERROR) ? ST_SYNTAX : error_code_reg;
                end
            end
        endcase

        // First byte of a component
        if (do_begin)
        begin
            if (too_many)
            begin
                phase_next      = PH_ERROR;
                error_code_next = ST_TOOMANY;
            end
            else if (is_digit)
            begin
                accum_next = {27'd0, digit};
                ovf_next   = 1'b0;
                hard_next  = 1'b0;
                phase_next = PH_DIGITS;
            end
            else
            begin
                phase_next      = PH_ERROR;
                error_code_next = ST_SYNTAX;
            end
        end

        // End of path: summary beat, then clear for the next path
        if (do_summary)
        begin
            if (phase_reg == PH_DIGITS || phase_reg == PH_MARKED)
            begin
                if (!ovf_reg)
                begin
                    res1.kind            = KIND_SUMMARY;
                    res1.status          = summary_status;
                    res1.component_count = seen_inc;
                    res1.last_result     = 1'b1;
                    n_res                = 2'd2;
                end
                else
                begin
                    res0.kind            = KIND_SUMMARY;
                    res0.status          = summary_status;
                    res0.component_count = seen_reg;
                    res0.last_result     = 1'b1;
                    n_res                = 2'd1;
                end
            end
            else
            begin
                res0.kind            = KIND_SUMMARY;
                res0.status          = summary_status;
                res0.component_count = seen_reg;
                res0.last_result     = 1'b1;
                n_res                = 2'd1;
            end
            phase_next      = PH_START;
            accum_next      = '0;
            ovf_next        = 1'b0;
            hard_next       = 1'b0;
            seen_next       = '0;
            error_code_next = ST_OK;
        end
    end

    // Parse state and limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            accum_reg      <= '0;
            ovf_reg        <= 1'b0;
            hard_reg       <= 1'b0;
            seen_reg       <= '0;
            error_code_reg <= ST_OK;
            max_comp_reg   <= MAX_COMP_RESET;
        end
        else
        begin
            if (accept_beat)
            begin
                phase_reg      <= phase_next;
                accum_reg      <= accum_next;
                ovf_reg        <= ovf_next;
                hard_reg       <= hard_next;
                seen_reg       <= seen_next;
                error_code_reg <= error_code_next;
            end
            if (cfg_we)
                max_comp_reg <= cfg_wdata;
        end
    end

    // Output queue count
    always_comb
    begin
        fifo_count_next = fifo_count_reg + (accept_beat ? n_res : 2'd0)
                          - (pop_beat ? 2'd1 : 2'd0);
    end

    // Output queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            fifo_count_reg <= fifo_count_next;
            if (pop_beat)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (accept_beat && n_res == 2'd1)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            else if (accept_beat && n_res == 2'd2)
                wr_ptr_reg <= ptr_inc(ptr_inc(wr_ptr_reg));
        end
    end

    // Output queue storage
    always_ff @(posedge clk)
    begin
        if (accept_beat && n_res != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (accept_beat && n_res == 2'd2)
            queue_reg[ptr_inc(wr_ptr_reg)] <= res1;
    end

    // Output channel from the queue head
    result_t head;
    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (fifo_count_reg != 2'd0);
    assign m_tdata  = {1'b0, head.component_count, head.status, head.index_value};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last_result;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= 2'(QUEUE_DEPTH))
        else $error("output queue count out of range");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("summary beat not marked last");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |-> error_code_reg != ST_OK)
        else $error("error phase without an error code");

    a_double_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept_beat && n_res == 2'd2 |=> fifo_count_reg != 2'd0)
        else $error("two-result beat left queue empty");

endmodule
`default_nettype wire
